FILE: hdl/distinct_top_k_extremes_assert.svh
// Assertion helpers for the RTL. The enclosing module must provide
// clk_i and rst_ni.
`ifndef DISTINCT_TOP_K_EXTREMES_ASSERT_SVH
`define DISTINCT_TOP_K_EXTREMES_ASSERT_SVH

// Same-cycle implication.
`define DTKE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtke assertion failed");

// Next-cycle implication.
`define DTKE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtke assertion failed");

`endif

FILE: hdl/dtke_pkg.sv
package dtke_pkg;

  localparam int TEMP_W        = 8;
  localparam int RANK_W        = 3;
  localparam int TDATA_W       = 16;
  localparam int TOP_COUNT_DEF = 5;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic {
    KIND_HIGH = 1'b0,
    KIND_LOW  = 1'b1
  } list_kind_e;

endpackage

FILE: hdl/dtke_insert.sv
// Combinational insertion of one sample into a sorted distinct list.
module dtke_insert #(
  parameter int TOP_COUNT = dtke_pkg::TOP_COUNT_DEF,
  parameter bit WANT_LOW  = 1'b0,
  localparam int CW = $clog2(TOP_COUNT + 1)
) (
  input  dtke_pkg::temp_t sample_i,
  input  dtke_pkg::temp_t list_i [TOP_COUNT],
  input  logic [CW-1:0]   count_i,
  output dtke_pkg::temp_t list_o [TOP_COUNT],
  output logic [CW-1:0]   count_o
);

  logic [TOP_COUNT-1:0] valid;
  logic [TOP_COUNT-1:0] hit;
  logic [TOP_COUNT-1:0] ins;   // monotonic: slot at or after insert point
  logic                 take;

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      valid[i] = CW'(i) < count_i;
      hit[i]   = valid[i] && (sample_i == list_i[i]);
      if (WANT_LOW) begin
        ins[i] = !valid[i] || (sample_i < list_i[i]);
      end else begin
        ins[i] = !valid[i] || (sample_i > list_i[i]);
      end
    end
  end

  // duplicates are dropped; a full list only takes a more extreme value
  assign take = !(|hit) && ins[TOP_COUNT-1];

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      list_o[i] = list_i[i];
      if (take && ins[i]) begin
        if (i == 0) begin
          list_o[i] = sample_i;
        end else if (!ins[i-1]) begin
          list_o[i] = sample_i;
        end else begin
          list_o[i] = list_i[i-1];
        end
      end
    end
    count_o = count_i;
    if (take && (count_i < CW'(TOP_COUNT))) begin
      count_o = count_i + CW'(1);
    end
  end

endmodule

FILE: hdl/dtke_report.sv
// Report snapshot and output register: holds both lists of one period and
// shifts them out one beat at a time.
module dtke_report #(
  parameter int TOP_COUNT = dtke_pkg::TOP_COUNT_DEF,
  localparam int CW = $clog2(TOP_COUNT + 1),
  localparam int RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          snap_load_i,
  input  dtke_pkg::temp_t               high_i [TOP_COUNT],
  input  logic [CW-1:0]                 high_cnt_i,
  input  dtke_pkg::temp_t               low_i [TOP_COUNT],
  input  logic [CW-1:0]                 low_cnt_i,
  output logic                          snap_free_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dtke_pkg::TDATA_W-1:0]  m_axis_tdata,  // rank[2:0], reported_value[10:3]
  output logic                          m_axis_tuser,  // list_kind
  output logic                          m_axis_tlast   // last_of_report
);

  localparam int RANK_OUT_W = dtke_pkg::RANK_W;
  localparam int PAD_W      = dtke_pkg::TDATA_W - dtke_pkg::TEMP_W - dtke_pkg::RANK_W;

  dtke_pkg::temp_t snap_high_q [TOP_COUNT];
  dtke_pkg::temp_t snap_low_q  [TOP_COUNT];
  logic [CW-1:0]   high_cnt_q, low_cnt_q;
  logic [RW-1:0]   rank_q;

  logic                  out_valid_q, out_last_q;
  dtke_pkg::list_kind_e  out_kind_q;
  logic [RANK_OUT_W-1:0] out_rank_q;
  dtke_pkg::temp_t       out_value_q;

  logic busy, emit, emit_high, last_emit;

  assign busy      = (high_cnt_q != '0) || (low_cnt_q != '0);
  assign emit      = busy && (!out_valid_q || m_axis_tready);
  assign emit_high = high_cnt_q != '0;
  assign last_emit = emit && !emit_high && (low_cnt_q == CW'(1));

  assign snap_free_o = !busy || last_emit;

  // snapshot lists: load on report, shift toward entry 0 as beats leave
  always_ff @(posedge clk_i) begin
    if (snap_load_i) begin
      snap_high_q <= high_i;
      snap_low_q  <= low_i;
    end else if (emit) begin
      for (int i = 0; i < TOP_COUNT - 1; i++) begin
        if (emit_high) begin
          snap_high_q[i] <= snap_high_q[i+1];
        end else begin
          snap_low_q[i] <= snap_low_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_cnt_q  <= '0;
      low_cnt_q   <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (snap_load_i) begin
        high_cnt_q <= high_cnt_i;
        low_cnt_q  <= low_cnt_i;
        rank_q     <= '0;
      end else if (emit) begin
        if (emit_high) begin
          high_cnt_q <= high_cnt_q - CW'(1);
          rank_q     <= (high_cnt_q == CW'(1)) ? '0 : rank_q + RW'(1);
        end else begin
          low_cnt_q <= low_cnt_q - CW'(1);
          rank_q    <= rank_q + RW'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= emit_high ? dtke_pkg::KIND_HIGH : dtke_pkg::KIND_LOW;
      out_rank_q  <= RANK_OUT_W'(rank_q);
      out_value_q <= emit_high ? snap_high_q[0] : snap_low_q[0];
      out_last_q  <= last_emit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_value_q, out_rank_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`include "distinct_top_k_extremes_assert.svh"

  `DTKE_ASSERT_NOW(a_load_when_free, snap_load_i, snap_free_o)
  `DTKE_ASSERT_NEXT(a_done_after_last, last_emit && !snap_load_i, !busy)
  `DTKE_ASSERT_NOW(a_last_is_low, out_valid_q && out_last_q, out_kind_q == dtke_pkg::KIND_LOW)

endmodule

FILE: hdl/distinct_top_k_extremes.sv
// Streaming top-k distinct extremes. Each input beat carries a signed 8-bit
// temperature; tlast marks the last sample of a report period. The block keeps
// the TOP_COUNT largest and TOP_COUNT smallest distinct values seen in the
// current period (duplicates ignored, the two lists independent). On a tlast
// beat that sample is taken in first, then the report is sent: the high list
// in descending order (tuser 0), then the low list in ascending order
// (tuser 1), rank counting from 0 at the most extreme entry, tlast on the
// final beat. Both lists then start empty. Rate: one sample per cycle, except
// while a tlast beat waits. The input register feeds a combinational
// compare-and-shift insertion into both lists; a report is copied into a
// snapshot so new samples keep flowing while it drains at one output beat per
// cycle while the receiver is ready. A tlast beat waits in the input register
// only while the previous report still has beats left.
module distinct_top_k_extremes #(
  parameter int TOP_COUNT = dtke_pkg::TOP_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dtke_pkg::TEMP_W-1:0]   s_axis_tdata,   // temperature[7:0]
  input  logic                          s_axis_tlast,   // end_of_period
  // report stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dtke_pkg::TDATA_W-1:0]  m_axis_tdata,   // rank[2:0], reported_value[10:3]
  output logic                          m_axis_tuser,   // list_kind
  output logic                          m_axis_tlast    // last_of_report
);

  localparam int CW = $clog2(TOP_COUNT + 1);

  // input register
  logic            in_valid_q, in_eop_q;
  dtke_pkg::temp_t in_temp_q;

  // live lists, sorted, entries at or beyond the count are don't-care
  dtke_pkg::temp_t high_q [TOP_COUNT];
  dtke_pkg::temp_t low_q  [TOP_COUNT];
  logic [CW-1:0]   high_cnt_q, low_cnt_q;

  dtke_pkg::temp_t high_d [TOP_COUNT];
  dtke_pkg::temp_t low_d  [TOP_COUNT];
  logic [CW-1:0]   high_cnt_d, low_cnt_d;

  logic snap_free, advance, snap_load;

  // a tlast sample moves on only when the snapshot can take the report
  assign advance       = in_valid_q && (!in_eop_q || snap_free);
  assign snap_load     = advance && in_eop_q;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_temp_q <= s_axis_tdata;
      in_eop_q  <= s_axis_tlast;
    end
  end

  dtke_insert #(
    .TOP_COUNT (TOP_COUNT),
    .WANT_LOW  (1'b0)
  ) u_ins_high (
    .sample_i (in_temp_q),
    .list_i   (high_q),
    .count_i  (high_cnt_q),
    .list_o   (high_d),
    .count_o  (high_cnt_d)
  );

  dtke_insert #(
    .TOP_COUNT (TOP_COUNT),
    .WANT_LOW  (1'b1)
  ) u_ins_low (
    .sample_i (in_temp_q),
    .list_i   (low_q),
    .count_i  (low_cnt_q),
    .list_o   (low_d),
    .count_o  (low_cnt_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  // counts drop to zero once the period's lists go to the snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
    end else if (advance) begin
      high_cnt_q <= in_eop_q ? '0 : high_cnt_d;
      low_cnt_q  <= in_eop_q ? '0 : low_cnt_d;
    end
  end

  dtke_report #(
    .TOP_COUNT (TOP_COUNT)
  ) u_report (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_load_i   (snap_load),
    .high_i        (high_d),
    .high_cnt_i    (high_cnt_d),
    .low_i         (low_d),
    .low_cnt_i     (low_cnt_d),
    .snap_free_o   (snap_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
